// File: rtl/core/svdt_pkg.sv
// Package for signed_value_to_display_text: character codes, limits and format codes.
`default_nettype none

package svdt_pkg;

    // Widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int NUM_CHARS = 8;
    localparam int MAG_W   = 24;   // holds any magnitude that is shown (<= 9999000)
    localparam int NUM_DEC = 7;    // decimal digits of the magnitude

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
    localparam logic [CHAR_W-1:0] CH_R     = 7'h72;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    // Range limits in thousandths
    localparam int HI_LIMIT_MILLI = 9999000;
    localparam int LO_LIMIT_MILLI = -999000;
    localparam int THOUSANDS_MIN  = 1000000;
    localparam int HUNDREDS_MIN   = 100000;
    localparam int TENS_MIN       = 10000;
    localparam int UNITS_MIN      = 1;
    localparam int ZERO_MIN       = -9;
    localparam int NEG_TENS_MIN   = -99999;
    localparam int NEG_UNITS_MIN  = -9999;

    typedef enum logic [3:0] {
        FMT_ERR_HI,
        FMT_ERR_LO,
        FMT_THOUSANDS,
        FMT_HUNDREDS,
        FMT_TENS,
        FMT_UNITS,
        FMT_ZERO,
        FMT_NEG_UNITS,
        FMT_NEG_TENS,
        FMT_NEG_HUNDREDS
    } fmt_t;

    typedef logic [CHAR_W-1:0] char_t;

    // ASCII digit from a BCD nibble
    function automatic char_t digit_char(input logic [3:0] d);
        digit_char = {3'b011, d};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/signed_value_to_display_text.sv
// Top level: signed thousandths value to eight-character indicator text.
// Registers: input register, then result register.
// Throughput: one item per cycle when not stalled; the decode between the two registers is
//   a row of parallel constant-reciprocal multipliers, one subtract per digit below the top one and a select.
// Reset: aresetn synchronous, active low; clears both valid flags, payload is not reset.
// Ready toward the source follows m_ready combinationally when both stages are full.
`default_nettype none

module signed_value_to_display_text (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input channel
    input  wire logic                                  s_valid,
    output      logic                                  s_ready,
    input  wire logic signed [svdt_pkg::VALUE_W-1:0]   s_value_milli,
    // result channel
    output      logic                                  m_valid,
    input  wire logic                                  m_ready,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char0,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char1,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char2,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char3,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char4,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char5,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char6,
    output      logic [svdt_pkg::CHAR_W-1:0]           m_char7,
    output      logic                                  m_out_of_range
);

    localparam int MAG_W   = svdt_pkg::MAG_W;
    localparam int NUM_DEC = svdt_pkg::NUM_DEC;

    // ------------------------------------------------------------------
    // Handshake: two-stage pipeline, each stage advances when the one
    // after it is empty or being drained.
    // ------------------------------------------------------------------
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_load;
    logic in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
        out_valid_next = out_load ? 1'b1 : ((m_valid && m_ready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register (payload, no reset)
    logic signed [svdt_pkg::VALUE_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            value_reg <= s_value_milli;
        end
    end

    // ------------------------------------------------------------------
    // Classify the value into one display format.
    // ------------------------------------------------------------------
    svdt_pkg::fmt_t fmt;

    always_comb begin
        if (value_reg > svdt_pkg::HI_LIMIT_MILLI) begin
            fmt = svdt_pkg::FMT_ERR_HI;
        end else if (value_reg < svdt_pkg::LO_LIMIT_MILLI) begin
            // -999.x lands here too: error wins
            fmt = svdt_pkg::FMT_ERR_LO;
        end else if (value_reg >= svdt_pkg::THOUSANDS_MIN) begin
            fmt = svdt_pkg::FMT_THOUSANDS;
        end else if (value_reg >= svdt_pkg::HUNDREDS_MIN) begin
            fmt = svdt_pkg::FMT_HUNDREDS;
        end else if (value_reg >= svdt_pkg::TENS_MIN) begin
            fmt = svdt_pkg::FMT_TENS;
        end else if (value_reg >= svdt_pkg::UNITS_MIN) begin
            fmt = svdt_pkg::FMT_UNITS;
        end else if (value_reg >= svdt_pkg::ZERO_MIN) begin
            fmt = svdt_pkg::FMT_ZERO;
        end else if (value_reg >= svdt_pkg::NEG_UNITS_MIN) begin
            fmt = svdt_pkg::FMT_NEG_UNITS;
        end else if (value_reg >= svdt_pkg::NEG_TENS_MIN) begin
            fmt = svdt_pkg::FMT_NEG_TENS;
        end else begin
            fmt = svdt_pkg::FMT_NEG_HUNDREDS;
        end
    end

    // ------------------------------------------------------------------
    // Magnitude and its decimal digits. Truncating by 10^k just drops
    // low digits, so every format picks its digits from one set.
    // quot[k] = mag / 10^k, each by its own constant reciprocal, all in
    // parallel: floor(mag * ceil(2^s / 10^k) / 2^s) with
    // s = MAG_W + clog2(10^k) is exact for any MAG_W-bit mag.
    // ------------------------------------------------------------------
    logic [svdt_pkg::VALUE_W-1:0] abs_value;
    logic [MAG_W-1:0]             mag;
    logic [MAG_W-1:0]             quot [NUM_DEC];
    logic [3:0]                   dig  [NUM_DEC];

    assign abs_value = value_reg[svdt_pkg::VALUE_W-1] ? svdt_pkg::VALUE_W'(-value_reg)
                                                      : value_reg;
    // out-of-range values are not shown, so their truncation is harmless
    assign mag = abs_value[MAG_W-1:0];
    assign quot[0] = mag;

    for (genvar k = 1; k < NUM_DEC; k++) begin : g_recip
        localparam longint DIV     = longint'(10) ** k;
        localparam int     SHIFT   = MAG_W + $clog2(DIV);
        localparam longint RECIP   = ((longint'(1) << SHIFT) + DIV - 1) / DIV;
        localparam int     RECIP_W = MAG_W + 1;
        localparam int     PROD_W  = MAG_W + RECIP_W;

        logic [PROD_W-1:0] prod;

        assign prod    = PROD_W'(mag) * PROD_W'(RECIP);
        assign quot[k] = MAG_W'(prod >> SHIFT);
    end

    for (genvar k = 0; k < NUM_DEC - 1; k++) begin : g_digit
        assign dig[k] = 4'(quot[k] - quot[k+1] * MAG_W'(10));
    end
    // top digit: quotient is already below ten for every shown value
    assign dig[NUM_DEC-1] = quot[NUM_DEC-1][3:0];

    // ------------------------------------------------------------------
    // Character select
    // ------------------------------------------------------------------
    svdt_pkg::char_t c_next [svdt_pkg::NUM_CHARS];
    logic            err_next;

    always_comb begin
        for (int i = 0; i < svdt_pkg::NUM_CHARS; i++) begin
            c_next[i] = svdt_pkg::CH_SPACE;
        end
        err_next = 1'b0;
        case (fmt)
            svdt_pkg::FMT_ERR_HI: begin
                c_next[0] = svdt_pkg::CH_E;
                c_next[1] = svdt_pkg::CH_R;
                c_next[2] = svdt_pkg::CH_R;
                err_next  = 1'b1;
            end
            svdt_pkg::FMT_ERR_LO: begin
                c_next[0] = svdt_pkg::CH_MINUS;
                c_next[1] = svdt_pkg::CH_E;
                c_next[2] = svdt_pkg::CH_R;
                c_next[3] = svdt_pkg::CH_R;
                err_next  = 1'b1;
            end
            svdt_pkg::FMT_THOUSANDS: begin       // dddd
                c_next[0] = svdt_pkg::digit_char(dig[6]);
                c_next[1] = svdt_pkg::digit_char(dig[5]);
                c_next[2] = svdt_pkg::digit_char(dig[4]);
                c_next[3] = svdt_pkg::digit_char(dig[3]);
            end
            svdt_pkg::FMT_HUNDREDS: begin        // ddd.d
                c_next[0] = svdt_pkg::digit_char(dig[5]);
                c_next[1] = svdt_pkg::digit_char(dig[4]);
                c_next[2] = svdt_pkg::digit_char(dig[3]);
                c_next[3] = svdt_pkg::CH_POINT;
                c_next[4] = svdt_pkg::digit_char(dig[2]);
            end
            svdt_pkg::FMT_TENS: begin            // dd.dd
                c_next[0] = svdt_pkg::digit_char(dig[4]);
                c_next[1] = svdt_pkg::digit_char(dig[3]);
                c_next[2] = svdt_pkg::CH_POINT;
                c_next[3] = svdt_pkg::digit_char(dig[2]);
                c_next[4] = svdt_pkg::digit_char(dig[1]);
            end
            svdt_pkg::FMT_UNITS: begin           // d.ddd
                c_next[0] = svdt_pkg::digit_char(dig[3]);
                c_next[1] = svdt_pkg::CH_POINT;
                c_next[2] = svdt_pkg::digit_char(dig[2]);
                c_next[3] = svdt_pkg::digit_char(dig[1]);
                c_next[4] = svdt_pkg::digit_char(dig[0]);
            end
            svdt_pkg::FMT_ZERO: begin            // 0000
                c_next[0] = svdt_pkg::CH_ZERO;
                c_next[1] = svdt_pkg::CH_ZERO;
                c_next[2] = svdt_pkg::CH_ZERO;
                c_next[3] = svdt_pkg::CH_ZERO;
            end
            svdt_pkg::FMT_NEG_UNITS: begin       // -d.dd
                c_next[0] = svdt_pkg::CH_MINUS;
                c_next[1] = svdt_pkg::digit_char(dig[3]);
                c_next[2] = svdt_pkg::CH_POINT;
                c_next[3] = svdt_pkg::digit_char(dig[2]);
                c_next[4] = svdt_pkg::digit_char(dig[1]);
            end
            svdt_pkg::FMT_NEG_TENS: begin        // -dd.d
                c_next[0] = svdt_pkg::CH_MINUS;
                c_next[1] = svdt_pkg::digit_char(dig[4]);
                c_next[2] = svdt_pkg::digit_char(dig[3]);
                c_next[3] = svdt_pkg::CH_POINT;
                c_next[4] = svdt_pkg::digit_char(dig[2]);
            end
            svdt_pkg::FMT_NEG_HUNDREDS: begin    // -ddd
                c_next[0] = svdt_pkg::CH_MINUS;
                c_next[1] = svdt_pkg::digit_char(dig[5]);
                c_next[2] = svdt_pkg::digit_char(dig[4]);
                c_next[3] = svdt_pkg::digit_char(dig[3]);
            end
            default: begin
                err_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register (payload, no reset)
    // ------------------------------------------------------------------
    svdt_pkg::char_t char_reg [svdt_pkg::NUM_CHARS];
    logic            err_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < svdt_pkg::NUM_CHARS; i++) begin
                char_reg[i] <= c_next[i];
            end
            err_reg <= err_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_char0        = char_reg[0];
    assign m_char1        = char_reg[1];
    assign m_char2        = char_reg[2];
    assign m_char3        = char_reg[3];
    assign m_char4        = char_reg[4];
    assign m_char5        = char_reg[5];
    assign m_char6        = char_reg[6];
    assign m_char7        = char_reg[7];
    assign m_out_of_range = err_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for signed_value_to_display_text: random and directed values, checked against a local formatter.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import svdt_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 8;     // block holds an input and a result register, leave margin
    localparam int HOLD_CYCLES  = 64;    // long output stall, well past the block's depth

    // One formatted display line as it appears on the result channel.
    typedef struct packed {
        char_t [NUM_CHARS-1:0] chars;
        logic                  out_of_range;
    } display_text_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [VALUE_W-1:0]   s_value_milli;
    logic                        m_valid;
    logic                        m_ready;
    logic [CHAR_W-1:0]           m_char0, m_char1, m_char2, m_char3;
    logic [CHAR_W-1:0]           m_char4, m_char5, m_char6, m_char7;
    logic                        m_out_of_range;

    // Texts still owed by the block, oldest first.
    display_text_t expected_text_q[$];

    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  max_send_gap   = 5;
    int  max_take_gap   = 5;
    bit  hold_request   = 1'b0;

    signed_value_to_display_text dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value_milli  (s_value_milli),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char0        (m_char0),
        .m_char1        (m_char1),
        .m_char2        (m_char2),
        .m_char3        (m_char3),
        .m_char4        (m_char4),
        .m_char5        (m_char5),
        .m_char6        (m_char6),
        .m_char7        (m_char7),
        .m_out_of_range (m_out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Formatter
    // ------------------------------------------------------------------

    // ASCII digit of n at the given decimal weight.
    function automatic char_t dec_char(input int n, input int weight);
        return CH_ZERO + char_t'((n / weight) % 10);
    endfunction

    // Text for one value in thousandths. Digits are truncated, never rounded.
    function automatic display_text_t format_value(input int v);
        display_text_t t;
        int            d;
        int            mag;
        for (int i = 0; i < NUM_CHARS; i++) begin
            t.chars[i] = CH_SPACE;
        end
        t.out_of_range = 1'b0;
        if (v > HI_LIMIT_MILLI) begin
            // includes 9999.001 .. 9999.999
            t.chars[0] = CH_E; t.chars[1] = CH_R; t.chars[2] = CH_R;
            t.out_of_range = 1'b1;
        end else if (v < LO_LIMIT_MILLI) begin
            // beats the -999.x values
            t.chars[0] = CH_MINUS; t.chars[1] = CH_E;
            t.chars[2] = CH_R;     t.chars[3] = CH_R;
            t.out_of_range = 1'b1;
        end else if (v >= THOUSANDS_MIN) begin
            d = v / 1000;
            t.chars[0] = dec_char(d, 1000); t.chars[1] = dec_char(d, 100);
            t.chars[2] = dec_char(d, 10);   t.chars[3] = dec_char(d, 1);
        end else if (v >= HUNDREDS_MIN) begin
            d = v / 100;
            t.chars[0] = dec_char(d, 1000); t.chars[1] = dec_char(d, 100);
            t.chars[2] = dec_char(d, 10);   t.chars[3] = CH_POINT;
            t.chars[4] = dec_char(d, 1);
        end else if (v >= TENS_MIN) begin
            d = v / 10;
            t.chars[0] = dec_char(d, 1000); t.chars[1] = dec_char(d, 100);
            t.chars[2] = CH_POINT;          t.chars[3] = dec_char(d, 10);
            t.chars[4] = dec_char(d, 1);
        end else if (v >= UNITS_MIN) begin
            t.chars[0] = dec_char(v, 1000); t.chars[1] = CH_POINT;
            t.chars[2] = dec_char(v, 100);  t.chars[3] = dec_char(v, 10);
            t.chars[4] = dec_char(v, 1);
        end else if (v >= ZERO_MIN) begin
            t.chars[0] = CH_ZERO; t.chars[1] = CH_ZERO;
            t.chars[2] = CH_ZERO; t.chars[3] = CH_ZERO;
        end else begin
            // negatives keep three digits; magnitude cannot overflow here
            mag = -v;
            t.chars[0] = CH_MINUS;
            if (v >= NEG_UNITS_MIN) begin
                d = mag / 10;
                t.chars[1] = dec_char(d, 100); t.chars[2] = CH_POINT;
                t.chars[3] = dec_char(d, 10);  t.chars[4] = dec_char(d, 1);
            end else if (v >= NEG_TENS_MIN) begin
                d = mag / 100;
                t.chars[1] = dec_char(d, 100); t.chars[2] = dec_char(d, 10);
                t.chars[3] = CH_POINT;         t.chars[4] = dec_char(d, 1);
            end else begin
                d = mag / 1000;
                t.chars[1] = dec_char(d, 100); t.chars[2] = dec_char(d, 10);
                t.chars[3] = dec_char(d, 1);
            end
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one value. Entered just after aclk rises; returns just after
    // the edge at which the item was taken. Valid is only dropped when a gap
    // is drawn, so it is never lowered and raised in the same step.
    task automatic send_value(input int value);
        int gap;
        gap = $urandom_range(max_send_gap, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_value_milli <= value;
        // values read just after the edge are the ones the edge sampled
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        expected_text_q.push_back(format_value(value));
    endtask

    // Random value from one of the display ranges, or from the whole word.
    function automatic int pick_value(input int range_sel);
        case (range_sel)
            0: return ($urandom_range(1, 0) == 1) ?
                      HI_LIMIT_MILLI + int'($urandom_range(2000, 1)) :
                      HI_LIMIT_MILLI + int'($urandom_range(32'h7FFFFFFF - HI_LIMIT_MILLI, 1));
            1: return ($urandom_range(1, 0) == 1) ?
                      LO_LIMIT_MILLI - int'($urandom_range(2000, 1)) :
                      LO_LIMIT_MILLI - int'($urandom_range(32'h7FFFFFFF + LO_LIMIT_MILLI + 1, 1));
            2: return int'($urandom_range(HI_LIMIT_MILLI, THOUSANDS_MIN));
            3: return int'($urandom_range(THOUSANDS_MIN - 1, HUNDREDS_MIN));
            4: return int'($urandom_range(HUNDREDS_MIN - 1, TENS_MIN));
            5: return int'($urandom_range(TENS_MIN - 1, UNITS_MIN));
            6: return -int'($urandom_range(9, 0));
            7: return -int'($urandom_range(9999, 10));
            8: return -int'($urandom_range(99999, 10000));
            9: return -int'($urandom_range(999000, 100000));
            default: return int'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                               input logic [CHAR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stall per item, plus one long hold on request.
    initial begin : result_taker
        display_text_t want;
        display_text_t got;
        int            stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = $urandom_range(max_take_gap, 0);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (m_valid !== 1'b1);
            got.chars = {m_char7, m_char6, m_char5, m_char4,
                         m_char3, m_char2, m_char1, m_char0};
            got.out_of_range = m_out_of_range;
            if (expected_text_q.size() == 0) begin
                $error("result with no value pending: chars %h", got.chars);
                mismatch_count++;
            end else begin
                want = expected_text_q.pop_front();
                for (int i = 0; i < NUM_CHARS; i++) begin
                    check_field($sformatf("char%0d", i), want.chars[i], got.chars[i]);
                end
                check_field("out_of_range", CHAR_W'(want.out_of_range),
                            CHAR_W'(got.out_of_range));
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every range boundary, both word extremes, and the -999.x override.
    task automatic test_range_edges();
        int edge_values[$];
        edge_values = '{32'h7FFFFFFF, 32'h80000000, 9999999, 9999001, 9999000,
                        1000000, 999999, 100000, 99999, 10000, 9999, 1, 0,
                        -1, -9, -10, -9999, -10000, -99999, -100000,
                        -999000, -999001, -999999, -1000000, 1234567};
        foreach (edge_values[i]) begin
            send_value(edge_values[i]);
        end
    endtask

    // Mostly in-range values spread over every format, with some full-word noise.
    task automatic test_random_formats(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            send_value(pick_value($urandom_range(10, 0)));
        end
    endtask

    // Full rate on both sides, no gaps anywhere.
    task automatic test_back_to_back(input int n_items);
        max_send_gap = 0;
        max_take_gap = 0;
        test_random_formats(n_items);
        max_send_gap = 5;
        max_take_gap = 5;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_output_stall(input int n_items);
        max_send_gap = 0;
        hold_request = 1'b1;
        test_random_formats(n_items);
        max_send_gap = 5;
    endtask

    initial begin : main_sequence
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_value_milli <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_range_edges();
        test_random_formats(300);
        test_back_to_back(80);
        test_output_stall(45);

        // last item taken: drop valid, then let the pipeline drain
        s_valid <= 1'b0;
        while (expected_text_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/svdt_pkg.sv
rtl/core/signed_value_to_display_text.sv
tb/tb_top.sv
